// ----- hdl/v3ga_pkg.sv -----
// ----------------------------------------------------------------------------
// v3ga_pkg: shared types and constants of the 3D vector ALU
// Opcodes, the result record, angle and square-root widths, the CORDIC
// arctangent table and the 2*pi divisor used by the angle reduction cells.
// ----------------------------------------------------------------------------
package v3ga_pkg;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_SCALE  = 4'd2,
    OP_LERP   = 4'd3,
    OP_DOT    = 4'd4,
    OP_CROSS  = 4'd5,
    OP_LENSQ  = 4'd6,
    OP_LEN    = 4'd7,
    OP_DISTSQ = 4'd8,
    OP_DIST   = 4'd9,
    OP_ROTX   = 4'd10,
    OP_ROTY   = 4'd11,
    OP_ROTZ   = 4'd12
  } opcode_e;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        sat;
  } result_t;

  // remainder path of the angle reduction, angle/CORDIC path, square-root path
  localparam int REM_W = 66;
  localparam int ANG_W = 34;
  localparam int SQ_W  = 64;

  localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;

  localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic signed [ANG_W-1:0] PI_Q30 =
    ANG_W'((PI_Q60 + (64'd1 << 29)) >> 30);
  localparam logic signed [ANG_W-1:0] TWO_PI_Q30 =
    ANG_W'(((PI_Q60 + (64'd1 << 29)) >> 30) << 1);
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 =
    ANG_W'((PI_Q60 + (64'd1 << 30)) >> 31);

  localparam int ATAN_N = 30;
  localparam logic [29:0] ATAN_Q30 [ATAN_N] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
    30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
    30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
    30'd32,        30'd16,        30'd8,         30'd4,         30'd2
  };

  // 2*pi with frac_bits+32 fraction bits
  function automatic logic [REM_W-1:0] two_pi_x(input int frac_bits);
    logic [63:0] v;
    v = (PI_Q60 + (64'd1 << (26 - frac_bits))) >> (27 - frac_bits);
    return REM_W'(v);
  endfunction

endpackage

// ----- hdl/v3ga_delay.sv -----
// ----------------------------------------------------------------------------
// v3ga_delay: fixed-length register line
// Passes a word through DEPTH registers to keep side paths aligned with the cells.
// ----------------------------------------------------------------------------
module v3ga_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  if (DEPTH == 0) begin : g_pass
    assign q_o = d_i;
  end else begin : g_line
    logic [WIDTH-1:0] tap_q [DEPTH];

    always_ff @(posedge clk_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end

    assign q_o = tap_q[DEPTH-1];
  end

endmodule

// ----- hdl/v3ga_div_cell.sv -----
// ----------------------------------------------------------------------------
// v3ga_div_cell: one restoring step of the reduction modulo 2*pi
// Subtract the shifted divisor when it fits; advance the sign flag.
// ----------------------------------------------------------------------------
module v3ga_div_cell #(
  parameter int FRAC_BITS = 16,
  parameter int SHIFT     = 0
) (
  input  logic                        clk_i,
  input  logic [v3ga_pkg::REM_W-1:0]  rem_i,
  input  logic                        neg_i,
  output logic [v3ga_pkg::REM_W-1:0]  rem_o,
  output logic                        neg_o
);

  localparam logic [v3ga_pkg::REM_W-1:0] STEP_SUB =
    v3ga_pkg::two_pi_x(FRAC_BITS) << SHIFT;

  logic [v3ga_pkg::REM_W-1:0] rem_q;
  logic                       neg_q;

  always_ff @(posedge clk_i) begin
    if (rem_i >= STEP_SUB) begin
      rem_q <= rem_i - STEP_SUB;
    end else begin
      rem_q <= rem_i;
    end
    neg_q <= neg_i;
  end

  assign rem_o = rem_q;
  assign neg_o = neg_q;

endmodule

// ----- hdl/v3ga_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// v3ga_cordic_cell: one CORDIC rotation-mode iteration
// Rotate towards zero residual angle by atan(2^-STEP); floor shifts.
// ----------------------------------------------------------------------------
module v3ga_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                               clk_i,
  input  logic signed [v3ga_pkg::ANG_W-1:0]  x_i,
  input  logic signed [v3ga_pkg::ANG_W-1:0]  y_i,
  input  logic signed [v3ga_pkg::ANG_W-1:0]  z_i,
  input  logic                               neg_i,
  output logic signed [v3ga_pkg::ANG_W-1:0]  x_o,
  output logic signed [v3ga_pkg::ANG_W-1:0]  y_o,
  output logic signed [v3ga_pkg::ANG_W-1:0]  z_o,
  output logic                               neg_o
);

  localparam logic signed [v3ga_pkg::ANG_W-1:0] ATAN =
    v3ga_pkg::ANG_W'(v3ga_pkg::ATAN_Q30[STEP]);

  logic signed [v3ga_pkg::ANG_W-1:0] dx, dy;
  logic signed [v3ga_pkg::ANG_W-1:0] x_q, y_q, z_q;
  logic                              neg_q;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  always_ff @(posedge clk_i) begin
    if (!z_i[v3ga_pkg::ANG_W-1]) begin
      x_q <= x_i - dx;
      y_q <= y_i + dy;
      z_q <= z_i - ATAN;
    end else begin
      x_q <= x_i + dx;
      y_q <= y_i - dy;
      z_q <= z_i + ATAN;
    end
    neg_q <= neg_i;
  end

  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;
  assign neg_o = neg_q;

endmodule

// ----- hdl/v3ga_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// v3ga_sqrt_cell: one bit of the integer square root
// Trial-subtract res+bit from the remainder; shift the partial root.
// ----------------------------------------------------------------------------
module v3ga_sqrt_cell #(
  parameter int BIT_IDX = 31
) (
  input  logic                       clk_i,
  input  logic [v3ga_pkg::SQ_W-1:0]  v_i,
  input  logic [v3ga_pkg::SQ_W-1:0]  r_i,
  output logic [v3ga_pkg::SQ_W-1:0]  v_o,
  output logic [v3ga_pkg::SQ_W-1:0]  r_o
);

  localparam int SQX = v3ga_pkg::SQ_W + 1;
  localparam logic [SQX-1:0] BIT_VAL = {{v3ga_pkg::SQ_W{1'b0}}, 1'b1} << (2 * BIT_IDX);

  logic [SQX-1:0]            trial;
  logic [v3ga_pkg::SQ_W-1:0] v_q, r_q;

  assign trial = {1'b0, r_i} + BIT_VAL;

  always_ff @(posedge clk_i) begin
    if ({1'b0, v_i} >= trial) begin
      v_q <= v_i - trial[v3ga_pkg::SQ_W-1:0];
      r_q <= (r_i >> 1) + BIT_VAL[v3ga_pkg::SQ_W-1:0];
    end else begin
      v_q <= v_i;
      r_q <= r_i >> 1;
    end
  end

  assign v_o = v_q;
  assign r_o = r_q;

endmodule

// ----- hdl/vec3_geometry_alu.sv -----
// ----------------------------------------------------------------------------
// vec3_geometry_alu: pipelined 3D vector ALU in signed fixed point
// Usage: drive opcode, A, B and scalar with start high; a transaction is
// taken at every edge where start is high and busy is low. busy stays low,
// so a new transaction may be issued in every cycle.
// Each transaction yields one result on rx_o/ry_o/rz_o/saturated_o, marked by
// done_o for exactly one cycle. Results leave in issue order.
// The rotation path is the longer one by default: 30-FRAC_BITS restoring
// cells reduce the angle modulo 2*pi, then come two fold stages,
// CORDIC_STEPS CORDIC cells and two multiply/round stages. The length path
// needs 2 stages plus 32 square-root cells; the shorter path is padded with
// register lines.
// Throughput: one transaction per cycle.
// Reset clears only the valid line; in-flight transactions are dropped.
// The receiver cannot stall: done_o marks data that must be taken.
// ----------------------------------------------------------------------------
module vec3_geometry_alu #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         opcode_i,
  input  logic signed [31:0] ax_i,
  input  logic signed [31:0] ay_i,
  input  logic signed [31:0] az_i,
  input  logic signed [31:0] bx_i,
  input  logic signed [31:0] by_i,
  input  logic signed [31:0] bz_i,
  input  logic signed [31:0] scalar_i,
  output logic               done_o,
  output logic signed [31:0] rx_o,
  output logic signed [31:0] ry_o,
  output logic signed [31:0] rz_o,
  output logic               saturated_o
);

  localparam int REM_W      = v3ga_pkg::REM_W;
  localparam int ANG_W      = v3ga_pkg::ANG_W;
  localparam int SQ_W       = v3ga_pkg::SQ_W;
  localparam int RES_W      = $bits(v3ga_pkg::result_t);
  localparam int QB         = 30 - FRAC_BITS;
  localparam int SQRT_CELLS = 32;
  localparam int ALU_LAT    = 2 + SQRT_CELLS;
  localparam int ROT_LAT    = QB + CORDIC_STEPS + 4;
  localparam int LAT        = (ROT_LAT > ALU_LAT) ? ROT_LAT : ALU_LAT;
  localparam int OPR_DEPTH  = QB + 2 + CORDIC_STEPS;

  localparam logic [REM_W-1:0]   TWO_PI_X = v3ga_pkg::two_pi_x(FRAC_BITS);
  localparam logic signed [65:0] BIG_POS  = 66'sh1_0000_0000;
  localparam logic signed [65:0] LIM_MAX  = 66'sh0_7FFF_FFFF;
  localparam logic signed [65:0] LIM_MIN  = -66'sh0_8000_0000;

  // --- helpers --------------------------------------------------------------
  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  // fixed-point product rounding, half away from zero
  function automatic logic signed [65:0] rnd_q(input logic [65:0] m, input logic neg);
    logic [65:0] r;
    r = (m + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return neg ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [65:0] rnd30(input logic signed [65:0] v);
    logic [65:0] mg;
    logic [65:0] r;
    mg = v[65] ? 66'(-v) : 66'(v);
    r  = (mg + (66'd1 << 29)) >> 30;
    return v[65] ? -$signed(r) : $signed(r);
  endfunction

  // {clipped, value}
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > LIM_MAX) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < LIM_MIN) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // --- input register and valid line ---------------------------------------
  logic                  accept;
  logic [LAT+1:0]        vld_q;
  v3ga_pkg::opcode_e     op_q;
  logic signed [31:0]    ax_q, ay_q, az_q, bx_q, by_q, bz_q, t_q;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= v3ga_pkg::opcode_e'(opcode_i);
    ax_q <= ax_i;
    ay_q <= ay_i;
    az_q <= az_i;
    bx_q <= bx_i;
    by_q <= by_i;
    bz_q <= bz_i;
    t_q  <= scalar_i;
  end

  // --- ALU path, stage B: operand select and magnitude products ------------
  logic signed [32:0] ex_ax, ex_ay, ex_az, ex_bx, ex_by, ex_bz, ex_t;
  logic signed [32:0] dx, dy, dz;
  logic               huge;
  logic signed [32:0] mp [6];
  logic signed [32:0] mq [6];
  logic signed [32:0] as_d [3];

  assign ex_ax = {ax_q[31], ax_q};
  assign ex_ay = {ay_q[31], ay_q};
  assign ex_az = {az_q[31], az_q};
  assign ex_bx = {bx_q[31], bx_q};
  assign ex_by = {by_q[31], by_q};
  assign ex_bz = {bz_q[31], bz_q};
  assign ex_t  = {t_q[31], t_q};
  assign dx    = ex_bx - ex_ax;
  assign dy    = ex_by - ex_ay;
  assign dz    = ex_bz - ex_az;
  assign huge  = (dx > 33'sd2147483647) || (dx < -33'sd2147483647) ||
                 (dy > 33'sd2147483647) || (dy < -33'sd2147483647) ||
                 (dz > 33'sd2147483647) || (dz < -33'sd2147483647);

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      mp[k] = '0;
      mq[k] = '0;
    end
    case (op_q)
      v3ga_pkg::OP_SCALE: begin
        mp[0] = ex_ax; mq[0] = ex_t;
        mp[1] = ex_ay; mq[1] = ex_t;
        mp[2] = ex_az; mq[2] = ex_t;
      end
      v3ga_pkg::OP_LERP: begin
        mp[0] = dx; mq[0] = ex_t;
        mp[1] = dy; mq[1] = ex_t;
        mp[2] = dz; mq[2] = ex_t;
      end
      v3ga_pkg::OP_DOT: begin
        mp[0] = ex_ax; mq[0] = ex_bx;
        mp[1] = ex_ay; mq[1] = ex_by;
        mp[2] = ex_az; mq[2] = ex_bz;
      end
      v3ga_pkg::OP_CROSS: begin
        mp[0] = ex_ay; mq[0] = ex_bz;
        mp[1] = ex_az; mq[1] = ex_by;
        mp[2] = ex_az; mq[2] = ex_bx;
        mp[3] = ex_ax; mq[3] = ex_bz;
        mp[4] = ex_ax; mq[4] = ex_by;
        mp[5] = ex_ay; mq[5] = ex_bx;
      end
      v3ga_pkg::OP_LENSQ, v3ga_pkg::OP_LEN: begin
        mp[0] = ex_ax; mq[0] = ex_ax;
        mp[1] = ex_ay; mq[1] = ex_ay;
        mp[2] = ex_az; mq[2] = ex_az;
      end
      v3ga_pkg::OP_DISTSQ, v3ga_pkg::OP_DIST: begin
        mp[0] = dx; mq[0] = dx;
        mp[1] = dy; mq[1] = dy;
        mp[2] = dz; mq[2] = dz;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (op_q == v3ga_pkg::OP_SUB) begin
      as_d[0] = ex_ax - ex_bx;
      as_d[1] = ex_ay - ex_by;
      as_d[2] = ex_az - ex_bz;
    end else begin
      as_d[0] = ex_ax + ex_bx;
      as_d[1] = ex_ay + ex_by;
      as_d[2] = ex_az + ex_bz;
    end
  end

  logic [65:0]        m_q [6];
  logic               sg_q [6];
  logic signed [32:0] as_q [3];
  logic signed [31:0] ax_b, ay_b, az_b;
  v3ga_pkg::opcode_e  op_b;
  logic               huge_b;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 6; k++) begin
      m_q[k]  <= 66'(mag33(mp[k])) * 66'(mag33(mq[k]));
      sg_q[k] <= mp[k][32] ^ mq[k][32];
    end
    for (int k = 0; k < 3; k++) begin
      as_q[k] <= as_d[k];
    end
    ax_b   <= ax_q;
    ay_b   <= ay_q;
    az_b   <= az_q;
    op_b   <= op_q;
    huge_b <= huge;
  end

  // --- ALU path, stage C: round, combine, clip -----------------------------
  logic signed [65:0]  rqv [6];
  logic [SQ_W-1:0]     sum_sq;
  logic [SQ_W:0]       sq_rnd;
  logic signed [65:0]  r0v, r1v, r2v;
  logic                use_sqrt;
  logic [32:0]         s0, s1, s2;
  v3ga_pkg::result_t   alu_d;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      rqv[k] = rnd_q(m_q[k], sg_q[k]);
    end
  end

  assign sum_sq = m_q[0][SQ_W-1:0] + m_q[1][SQ_W-1:0] + m_q[2][SQ_W-1:0];
  assign sq_rnd = ({1'b0, sum_sq} + ((SQ_W+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;

  always_comb begin
    r0v      = '0;
    r1v      = '0;
    r2v      = '0;
    use_sqrt = 1'b0;
    case (op_b)
      v3ga_pkg::OP_ADD, v3ga_pkg::OP_SUB: begin
        r0v = 66'(as_q[0]);
        r1v = 66'(as_q[1]);
        r2v = 66'(as_q[2]);
      end
      v3ga_pkg::OP_SCALE: begin
        r0v = rqv[0];
        r1v = rqv[1];
        r2v = rqv[2];
      end
      v3ga_pkg::OP_LERP: begin
        r0v = 66'(ax_b) + rqv[0];
        r1v = 66'(ay_b) + rqv[1];
        r2v = 66'(az_b) + rqv[2];
      end
      v3ga_pkg::OP_DOT: begin
        r0v = rqv[0] + rqv[1] + rqv[2];
      end
      v3ga_pkg::OP_CROSS: begin
        r0v = rqv[0] - rqv[1];
        r1v = rqv[2] - rqv[3];
        r2v = rqv[4] - rqv[5];
      end
      v3ga_pkg::OP_LENSQ: begin
        r0v = 66'(sq_rnd);
      end
      v3ga_pkg::OP_DISTSQ: begin
        r0v = huge_b ? BIG_POS : 66'(sq_rnd);
      end
      v3ga_pkg::OP_LEN: begin
        use_sqrt = 1'b1;
      end
      v3ga_pkg::OP_DIST: begin
        // out of range component: clip straight to the top
        if (huge_b) begin
          r0v = BIG_POS;
        end else begin
          use_sqrt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign s0        = sat32(r0v);
  assign s1        = sat32(r1v);
  assign s2        = sat32(r2v);
  assign alu_d.x   = s0[31:0];
  assign alu_d.y   = s1[31:0];
  assign alu_d.z   = s2[31:0];
  assign alu_d.sat = s0[32] | s1[32] | s2[32];

  v3ga_pkg::result_t alu_q;
  logic              use_sqrt_q;
  logic [SQ_W-1:0]   sum_q;

  always_ff @(posedge clk_i) begin
    alu_q      <= alu_d;
    use_sqrt_q <= use_sqrt;
    sum_q      <= sum_sq;
  end

  // --- square-root cell chain ----------------------------------------------
  logic [SQ_W-1:0] sq_v [SQRT_CELLS+1];
  logic [SQ_W-1:0] sq_r [SQRT_CELLS+1];

  assign sq_v[0] = sum_q;
  assign sq_r[0] = '0;

  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
    v3ga_sqrt_cell #(
      .BIT_IDX(SQRT_CELLS - 1 - k)
    ) u_cell (
      .clk_i(clk_i),
      .v_i  (sq_v[k]),
      .r_i  (sq_r[k]),
      .v_o  (sq_v[k+1]),
      .r_o  (sq_r[k+1])
    );
  end

  // hold the plain result beside the root
  logic [RES_W:0]    alu_dl;
  v3ga_pkg::result_t alu_dr;
  v3ga_pkg::result_t alu_m;

  v3ga_delay #(
    .WIDTH(RES_W + 1),
    .DEPTH(SQRT_CELLS)
  ) u_alu_dly (
    .clk_i(clk_i),
    .d_i  ({use_sqrt_q, alu_q}),
    .q_o  (alu_dl)
  );

  assign alu_dr = alu_dl[RES_W-1:0];

  always_comb begin
    alu_m = alu_dr;
    if (alu_dl[RES_W]) begin
      // root is below 2^32; the top bit means it is beyond the signed range
      alu_m.x   = sq_r[SQRT_CELLS][31] ? 32'h7FFF_FFFF : sq_r[SQRT_CELLS][31:0];
      alu_m.y   = '0;
      alu_m.z   = '0;
      alu_m.sat = sq_r[SQRT_CELLS][31];
    end
  end

  logic [RES_W-1:0] alu_pd;

  v3ga_delay #(
    .WIDTH(RES_W),
    .DEPTH(LAT - ALU_LAT)
  ) u_alu_pad (
    .clk_i(clk_i),
    .d_i  (alu_m),
    .q_o  (alu_pd)
  );

  // --- rotation path: angle reduction cells --------------------------------
  logic [31:0]      t_mag;
  logic [REM_W-1:0] dv_rem [QB+1];
  logic             dv_neg [QB+1];

  assign t_mag     = t_q[31] ? (~t_q + 32'd1) : t_q;
  assign dv_rem[0] = {2'b00, t_mag, 32'h0};
  assign dv_neg[0] = t_q[31];

  for (genvar j = 0; j < QB; j++) begin : g_div
    v3ga_div_cell #(
      .FRAC_BITS(FRAC_BITS),
      .SHIFT    (QB - 1 - j)
    ) u_cell (
      .clk_i(clk_i),
      .rem_i(dv_rem[j]),
      .neg_i(dv_neg[j]),
      .rem_o(dv_rem[j+1]),
      .neg_o(dv_neg[j+1])
    );
  end

  // fold negative angles into [0, 2*pi) and round to Q30
  logic [REM_W-1:0]        rem_f;
  logic [REM_W-1:0]        rem_r;
  logic signed [ANG_W-1:0] za_q;

  assign rem_f = (dv_neg[QB] && (dv_rem[QB] != '0)) ? (TWO_PI_X - dv_rem[QB]) : dv_rem[QB];
  assign rem_r = (rem_f + (66'd1 << (FRAC_BITS + 1))) >> (FRAC_BITS + 2);

  always_ff @(posedge clk_i) begin
    za_q <= ANG_W'(rem_r);
  end

  // move into (-pi, pi], then into [-pi/2, pi/2] with a negate flag
  logic signed [ANG_W-1:0] z1;
  logic signed [ANG_W-1:0] zb_d;
  logic                    fneg_d;
  logic signed [ANG_W-1:0] zb_q;
  logic                    fneg_q;

  assign z1 = (za_q > v3ga_pkg::PI_Q30) ? (za_q - v3ga_pkg::TWO_PI_Q30) : za_q;

  always_comb begin
    zb_d   = z1;
    fneg_d = 1'b0;
    if (z1 > v3ga_pkg::HALF_PI_Q30) begin
      zb_d   = z1 - v3ga_pkg::PI_Q30;
      fneg_d = 1'b1;
    end else if (z1 < -v3ga_pkg::HALF_PI_Q30) begin
      zb_d   = z1 + v3ga_pkg::PI_Q30;
      fneg_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    zb_q   <= zb_d;
    fneg_q <= fneg_d;
  end

  // --- CORDIC cell chain ---------------------------------------------------
  logic signed [ANG_W-1:0] cx [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] cy [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] cz [CORDIC_STEPS+1];
  logic                    cn [CORDIC_STEPS+1];

  assign cx[0] = v3ga_pkg::CORDIC_GAIN;
  assign cy[0] = '0;
  assign cz[0] = zb_q;
  assign cn[0] = fneg_q;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    v3ga_cordic_cell #(
      .STEP(i)
    ) u_cell (
      .clk_i(clk_i),
      .x_i  (cx[i]),
      .y_i  (cy[i]),
      .z_i  (cz[i]),
      .neg_i(cn[i]),
      .x_o  (cx[i+1]),
      .y_o  (cy[i+1]),
      .z_o  (cz[i+1]),
      .neg_o(cn[i+1])
    );
  end

  // operands travel beside the angle
  logic [99:0]       opr_dl;
  v3ga_pkg::opcode_e rd_op;
  logic signed [31:0] rd_ax, rd_ay, rd_az;

  v3ga_delay #(
    .WIDTH(100),
    .DEPTH(OPR_DEPTH)
  ) u_opr_dly (
    .clk_i(clk_i),
    .d_i  ({op_q, ax_q, ay_q, az_q}),
    .q_o  (opr_dl)
  );

  assign rd_op = v3ga_pkg::opcode_e'(opr_dl[99:96]);
  assign rd_ax = opr_dl[95:64];
  assign rd_ay = opr_dl[63:32];
  assign rd_az = opr_dl[31:0];

  // --- rotation: products, then sum and round ------------------------------
  logic                    s_flip;
  logic signed [ANG_W-1:0] c_r, s_r;
  logic signed [31:0]      p_r, q_r;
  logic signed [65:0]      pc_d, qs_d, ps_d, qc_d;

  // about y the sine term enters with the opposite sign
  assign s_flip = cn[CORDIC_STEPS] ^ (rd_op == v3ga_pkg::OP_ROTY);
  assign c_r    = cn[CORDIC_STEPS] ? -cx[CORDIC_STEPS] : cx[CORDIC_STEPS];
  assign s_r    = s_flip ? -cy[CORDIC_STEPS] : cy[CORDIC_STEPS];

  always_comb begin
    case (rd_op)
      v3ga_pkg::OP_ROTX: begin
        p_r = rd_ay;
        q_r = rd_az;
      end
      v3ga_pkg::OP_ROTY: begin
        p_r = rd_ax;
        q_r = rd_az;
      end
      default: begin
        p_r = rd_ax;
        q_r = rd_ay;
      end
    endcase
  end

  assign pc_d = p_r * c_r;
  assign qs_d = q_r * s_r;
  assign ps_d = p_r * s_r;
  assign qc_d = q_r * c_r;

  logic signed [65:0] pc_q, qs_q, ps_q, qc_q;
  v3ga_pkg::opcode_e  rop_q;
  logic signed [31:0] rax_q, ray_q, raz_q;

  always_ff @(posedge clk_i) begin
    pc_q  <= pc_d;
    qs_q  <= qs_d;
    ps_q  <= ps_d;
    qc_q  <= qc_d;
    rop_q <= rd_op;
    rax_q <= rd_ax;
    ray_q <= rd_ay;
    raz_q <= rd_az;
  end

  logic [32:0]       fs, gs;
  logic              rot_sel;
  v3ga_pkg::result_t rot_d;

  assign fs      = sat32(rnd30(pc_q - qs_q));
  assign gs      = sat32(rnd30(ps_q + qc_q));
  assign rot_sel = (rop_q == v3ga_pkg::OP_ROTX) || (rop_q == v3ga_pkg::OP_ROTY) ||
                   (rop_q == v3ga_pkg::OP_ROTZ);

  always_comb begin
    rot_d.sat = fs[32] | gs[32];
    case (rop_q)
      v3ga_pkg::OP_ROTX: begin
        rot_d.x = rax_q;
        rot_d.y = fs[31:0];
        rot_d.z = gs[31:0];
      end
      v3ga_pkg::OP_ROTY: begin
        rot_d.x = fs[31:0];
        rot_d.y = ray_q;
        rot_d.z = gs[31:0];
      end
      default: begin
        rot_d.x = fs[31:0];
        rot_d.y = gs[31:0];
        rot_d.z = raz_q;
      end
    endcase
  end

  v3ga_pkg::result_t rot_q;
  logic              rot_sel_q;

  always_ff @(posedge clk_i) begin
    rot_q     <= rot_d;
    rot_sel_q <= rot_sel;
  end

  logic [RES_W:0]    rot_pd;
  v3ga_pkg::result_t rot_pr;

  v3ga_delay #(
    .WIDTH(RES_W + 1),
    .DEPTH(LAT - ROT_LAT)
  ) u_rot_pad (
    .clk_i(clk_i),
    .d_i  ({rot_sel_q, rot_q}),
    .q_o  (rot_pd)
  );

  assign rot_pr = rot_pd[RES_W-1:0];

  // --- output register -----------------------------------------------------
  v3ga_pkg::result_t res_q;

  always_ff @(posedge clk_i) begin
    if (rot_pd[RES_W]) begin
      res_q <= rot_pr;
    end else begin
      res_q <= alu_pd;
    end
  end

  assign done_o      = vld_q[LAT+1];
  assign rx_o        = res_q.x;
  assign ry_o        = res_q.y;
  assign rz_o        = res_q.z;
  assign saturated_o = res_q.sat;

  // --- assertions ----------------------------------------------------------
  a_latency_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(LAT+2) done_o)
    else $error("transaction did not complete after the pipeline latency");

  a_latency_bwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LAT+2))
    else $error("result strobe without a matching transaction");

  a_sat_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && saturated_o) |->
      (rx_o == 32'h7FFF_FFFF || rx_o == 32'h8000_0000 ||
       ry_o == 32'h7FFF_FFFF || ry_o == 32'h8000_0000 ||
       rz_o == 32'h7FFF_FFFF || rz_o == 32'h8000_0000))
    else $error("saturated flag set with no component at a limit");

endmodule
